>>> hw/rtl/ball_pair_collision_response_macros.svh
// Assertion helpers for the collision response block.
`ifndef BALL_PAIR_COLLISION_RESPONSE_MACROS_SVH
`define BALL_PAIR_COLLISION_RESPONSE_MACROS_SVH

// same-cycle implication
`define BPCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BPCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bpcr_pkg.sv
// ----------------------------------------------------------------------------
// bpcr_pkg
// Types and constants of the disc pair collision response pipeline.
// ----------------------------------------------------------------------------
package bpcr_pkg;

  localparam int QB  = 35;           // quotient bits per divider lane
  localparam int NL  = 6;            // divider lanes
  localparam int RW  = 120;          // divider remainder width
  localparam int DW  = 84;           // impulse denominator width
  localparam int NPRE = 7;
  localparam int NPOST = 3;
  localparam int NS  = NPRE + QB + NPOST;

  localparam logic [16:0] REST_RESET = 17'd60293;

  localparam int LANE_AX = 0;
  localparam int LANE_AY = 1;
  localparam int LANE_BX = 2;
  localparam int LANE_BY = 3;
  localparam int LANE_CX = 4;
  localparam int LANE_CY = 5;

  typedef struct packed {
    logic               ov;
    logic               resp;
    logic               sx;
    logic               sy;
    logic               snx;
    logic               sny;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } carry_t;

  function automatic logic signed [31:0] sat32(input logic signed [40:0] x);
    logic signed [31:0] r;
    if (x > 41'sd2147483647) r = 32'sh7fffffff;
    else if (x < -41'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

>>> hw/rtl/ball_pair_collision_response.sv
// ----------------------------------------------------------------------------
// ball_pair_collision_response
// 45 pipeline stages and the output register lie between input word and
// output word; throughput one pair per cycle while the output is not stalled, set by the 35-stage
// restoring divider that runs six quotient lanes side by side.
// Reset clears all valid bits and sets restitution to 60293 (0.92).
// ----------------------------------------------------------------------------
`include "ball_pair_collision_response_macros.svh"

module ball_pair_collision_response (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [16:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  a_pos_x,
  input  logic signed [31:0]  a_pos_y,
  input  logic signed [31:0]  b_pos_x,
  input  logic signed [31:0]  b_pos_y,
  input  logic [30:0]         a_radius,
  input  logic [30:0]         b_radius,
  input  logic signed [31:0]  a_vel_x,
  input  logic signed [31:0]  a_vel_y,
  input  logic signed [31:0]  b_vel_x,
  input  logic signed [31:0]  b_vel_y,
  input  logic [15:0]         a_mass,
  input  logic [15:0]         b_mass,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                overlap,
  output logic                responded,
  output logic signed [31:0]  new_a_vel_x,
  output logic signed [31:0]  new_a_vel_y,
  output logic signed [31:0]  new_b_vel_x,
  output logic signed [31:0]  new_b_vel_y
);
  import bpcr_pkg::*;

  logic [16:0]    restitution;
  logic [NS-1:0]  vld;
  logic           en;

  // pipeline moves unless the last stage and the output register are both full and the output is stalled
  assign en       = !(out_valid && out_stall && vld[NS-1]);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      restitution <= REST_RESET;
    end else if (cfg_write) begin
      restitution <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage 1: differences, radius sum, masses
  logic signed [32:0] s1_dx, s1_dy, s1_dvx, s1_dvy;
  logic [31:0]        s1_rsum;
  logic [15:0]        s1_m1, s1_m2;
  logic [16:0]        s1_mt;
  carry_t             s1_c;
  logic               both_zero;
  logic [15:0]        m1_in, m2_in;

  assign both_zero = (a_mass == 16'd0) && (b_mass == 16'd0);
  assign m1_in     = both_zero ? 16'd1 : a_mass;
  assign m2_in     = both_zero ? 16'd1 : b_mass;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx   <= {b_pos_x[31], b_pos_x} - {a_pos_x[31], a_pos_x};
      s1_dy   <= {b_pos_y[31], b_pos_y} - {a_pos_y[31], a_pos_y};
      s1_dvx  <= {b_vel_x[31], b_vel_x} - {a_vel_x[31], a_vel_x};
      s1_dvy  <= {b_vel_y[31], b_vel_y} - {a_vel_y[31], a_vel_y};
      s1_rsum <= {1'b0, a_radius} + {1'b0, b_radius};
      s1_m1   <= m1_in;
      s1_m2   <= m2_in;
      s1_mt   <= {1'b0, m1_in} + {1'b0, m2_in};
      s1_c    <= '{ov: 1'b0, resp: 1'b0, sx: 1'b0, sy: 1'b0, snx: 1'b0, sny: 1'b0,
                   avx: a_vel_x, avy: a_vel_y, bvx: b_vel_x, bvy: b_vel_y};
    end
  end

  // stage 2: squares, velocity products, mass-weighted velocities
  logic signed [65:0] s2_dxx, s2_dyy, s2_pdx, s2_pdy;
  logic [63:0]        s2_rr;
  logic signed [48:0] s2_cax, s2_cbx, s2_cay, s2_cby;
  logic signed [32:0] s2_dx, s2_dy;
  logic [15:0]        s2_m1, s2_m2;
  logic [16:0]        s2_mt;
  carry_t             s2_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dxx <= s1_dx * s1_dx;
      s2_dyy <= s1_dy * s1_dy;
      s2_pdx <= s1_dvx * s1_dx;
      s2_pdy <= s1_dvy * s1_dy;
      s2_rr  <= s1_rsum * s1_rsum;
      s2_cax <= $signed({1'b0, s1_m1}) * s1_c.avx;
      s2_cbx <= $signed({1'b0, s1_m2}) * s1_c.bvx;
      s2_cay <= $signed({1'b0, s1_m1}) * s1_c.avy;
      s2_cby <= $signed({1'b0, s1_m2}) * s1_c.bvy;
      s2_dx  <= s1_dx;
      s2_dy  <= s1_dy;
      s2_m1  <= s1_m1;
      s2_m2  <= s1_m2;
      s2_mt  <= s1_mt;
      s2_c   <= s1_c;
    end
  end

  // stage 3: squared distance, dot product, momentum sums
  logic [66:0]        s3_d;
  logic signed [66:0] s3_dot;
  logic [63:0]        s3_rr;
  logic signed [49:0] s3_nx, s3_ny;
  logic signed [32:0] s3_dx, s3_dy;
  logic [15:0]        s3_m1, s3_m2;
  logic [16:0]        s3_mt;
  carry_t             s3_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d   <= 67'(s2_dxx) + 67'(s2_dyy);
      s3_dot <= 67'(s2_pdx) + 67'(s2_pdy);
      s3_rr  <= s2_rr;
      s3_nx  <= 50'(s2_cax) + 50'(s2_cbx);
      s3_ny  <= 50'(s2_cay) + 50'(s2_cby);
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_m1  <= s2_m1;
      s3_m2  <= s2_m2;
      s3_mt  <= s2_mt;
      s3_c   <= s2_c;
    end
  end

  // stage 4: overlap test, partial products of dot*d and mt*D
  logic signed [67:0] s4_txl, s4_tyl;
  logic signed [65:0] s4_txh, s4_tyh;
  logic [50:0]        s4_denl;
  logic [49:0]        s4_denh;
  logic signed [49:0] s4_nx, s4_ny;
  logic [15:0]        s4_m1, s4_m2;
  logic [16:0]        s4_mt;
  carry_t             s4_c;
  carry_t             s3_cx;
  logic               s3_ov;

  assign s3_ov = s3_d < {3'b0, s3_rr};

  always_comb begin
    s3_cx      = s3_c;
    s3_cx.ov   = s3_ov;
    s3_cx.resp = s3_ov && s3_dot[66];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_txl  <= $signed({1'b0, s3_dot[33:0]}) * s3_dx;
      s4_tyl  <= $signed({1'b0, s3_dot[33:0]}) * s3_dy;
      s4_txh  <= $signed(s3_dot[66:34]) * s3_dx;
      s4_tyh  <= $signed(s3_dot[66:34]) * s3_dy;
      s4_denl <= s3_d[33:0] * s3_mt;
      s4_denh <= s3_d[66:34] * s3_mt;
      s4_nx   <= s3_nx;
      s4_ny   <= s3_ny;
      s4_m1   <= s3_m1;
      s4_m2   <= s3_m2;
      s4_mt   <= s3_mt;
      s4_c    <= s3_cx;
    end
  end

  // stage 5: assemble dot*dx, dot*dy and the impulse denominator
  logic signed [99:0] s5_tx, s5_ty;
  logic [DW-1:0]      s5_den;
  logic signed [49:0] s5_nx, s5_ny;
  logic [15:0]        s5_m1, s5_m2;
  logic [16:0]        s5_mt;
  carry_t             s5_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tx  <= {s4_txh, 34'b0} + 100'(s4_txl);
      s5_ty  <= {s4_tyh, 34'b0} + 100'(s4_tyl);
      s5_den <= {s4_denh, 34'b0} + DW'(s4_denl);
      s5_nx  <= s4_nx;
      s5_ny  <= s4_ny;
      s5_m1  <= s4_m1;
      s5_m2  <= s4_m2;
      s5_mt  <= s4_mt;
      s5_c   <= s4_c;
    end
  end

  // stage 6: magnitudes, split products by 2*m
  logic [99:0] s5_atx, s5_aty;
  logic [16:0] s5_ka, s5_kb;
  carry_t      s5_cx;
  logic [66:0] s6_pl [0:3];
  logic [66:0] s6_ph [0:3];
  logic [49:0] s6_anx, s6_any;
  logic [DW-1:0] s6_den;
  logic [16:0] s6_mt;
  carry_t      s6_c;

  assign s5_atx = s5_tx[99] ? 100'(-s5_tx) : 100'(s5_tx);
  assign s5_aty = s5_ty[99] ? 100'(-s5_ty) : 100'(s5_ty);
  assign s5_ka  = {s5_m2, 1'b0};
  assign s5_kb  = {s5_m1, 1'b0};

  always_comb begin
    s5_cx     = s5_c;
    s5_cx.sx  = s5_tx[99];
    s5_cx.sy  = s5_ty[99];
    s5_cx.snx = s5_nx[49];
    s5_cx.sny = s5_ny[49];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_pl[LANE_AX] <= s5_atx[49:0] * s5_ka;
      s6_ph[LANE_AX] <= s5_atx[99:50] * s5_ka;
      s6_pl[LANE_AY] <= s5_aty[49:0] * s5_ka;
      s6_ph[LANE_AY] <= s5_aty[99:50] * s5_ka;
      s6_pl[LANE_BX] <= s5_atx[49:0] * s5_kb;
      s6_ph[LANE_BX] <= s5_atx[99:50] * s5_kb;
      s6_pl[LANE_BY] <= s5_aty[49:0] * s5_kb;
      s6_ph[LANE_BY] <= s5_aty[99:50] * s5_kb;
      s6_anx <= s5_nx[49] ? 50'(-s5_nx) : 50'(s5_nx);
      s6_any <= s5_ny[49] ? 50'(-s5_ny) : 50'(s5_ny);
      s6_den <= s5_den;
      s6_mt  <= s5_mt;
      s6_c   <= s5_cx;
    end
  end

  // stage 7 loads divider slot 0; slots 1..QB retire one quotient bit each
  logic [RW-1:0] dv_rem [0:QB][0:NL-1];
  logic [QB-1:0] dv_q   [0:QB][0:NL-1];
  logic [DW-1:0] dv_den [0:QB];
  logic [16:0]   dv_mt  [0:QB];
  carry_t        dv_c   [0:QB];

  logic [RW-1:0] st_rem [0:QB-1][0:NL-1];
  logic          st_ge  [0:QB-1][0:NL-1];

  always_comb begin
    logic [RW-1:0] dsh;
    for (int k = 0; k < QB; k++) begin
      for (int l = 0; l < NL; l++) begin
        dsh = (l < LANE_CX) ? RW'(dv_den[k]) : RW'(dv_mt[k]);
        dsh = dsh << (QB - 1 - k);
        st_ge[k][l]  = dv_rem[k][l] >= dsh;
        st_rem[k][l] = st_ge[k][l] ? dv_rem[k][l] - dsh : dv_rem[k][l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANE_CX; l++) begin
        dv_rem[0][l] <= RW'({s6_ph[l], 50'b0}) + RW'(s6_pl[l]);
      end
      dv_rem[0][LANE_CX] <= RW'(s6_anx);
      dv_rem[0][LANE_CY] <= RW'(s6_any);
      for (int l = 0; l < NL; l++) begin
        dv_q[0][l] <= '0;
      end
      dv_den[0] <= s6_den;
      dv_mt[0]  <= s6_mt;
      dv_c[0]   <= s6_c;
      for (int k = 0; k < QB; k++) begin
        for (int l = 0; l < NL; l++) begin
          dv_rem[k+1][l] <= st_rem[k][l];
          dv_q[k+1][l]   <= {dv_q[k][l][QB-2:0], st_ge[k][l]};
        end
        dv_den[k+1] <= dv_den[k];
        dv_mt[k+1]  <= dv_mt[k];
        dv_c[k+1]   <= dv_c[k];
      end
    end
  end

  // post 1: apply impulse, centre-of-mass velocity, relative velocity
  logic signed [36:0] qs [0:NL-1];
  logic signed [36:0] nv [0:3];
  logic signed [36:0] cmx, cmy;
  logic signed [37:0] p1_diff [0:3];
  logic signed [36:0] p1_cm [0:1];
  carry_t             p1_c;
  carry_t             qc;

  always_comb begin
    qc = dv_c[QB];
    for (int l = 0; l < NL; l++) begin
      qs[l] = $signed({2'b0, dv_q[QB][l]});
    end
    // the b impulse carries the opposite sign
    nv[LANE_AX] = 37'(qc.avx) + (qc.sx ? -qs[LANE_AX] : qs[LANE_AX]);
    nv[LANE_AY] = 37'(qc.avy) + (qc.sy ? -qs[LANE_AY] : qs[LANE_AY]);
    nv[LANE_BX] = 37'(qc.bvx) + (qc.sx ? qs[LANE_BX] : -qs[LANE_BX]);
    nv[LANE_BY] = 37'(qc.bvy) + (qc.sy ? qs[LANE_BY] : -qs[LANE_BY]);
    cmx = qc.snx ? -qs[LANE_CX] : qs[LANE_CX];
    cmy = qc.sny ? -qs[LANE_CY] : qs[LANE_CY];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_diff[LANE_AX] <= 38'(nv[LANE_AX]) - 38'(cmx);
      p1_diff[LANE_AY] <= 38'(nv[LANE_AY]) - 38'(cmy);
      p1_diff[LANE_BX] <= 38'(nv[LANE_BX]) - 38'(cmx);
      p1_diff[LANE_BY] <= 38'(nv[LANE_BY]) - 38'(cmy);
      p1_cm[0] <= cmx;
      p1_cm[1] <= cmy;
      p1_c     <= qc;
    end
  end

  // post 2: restitution scaling
  logic signed [55:0] p2_prod [0:3];
  logic signed [36:0] p2_cm [0:1];
  carry_t             p2_c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        p2_prod[l] <= p1_diff[l] * $signed({1'b0, restitution});
      end
      p2_cm <= p1_cm;
      p2_c  <= p1_c;
    end
  end

  // post 3: floor shift, add back vcm, saturate, select
  logic signed [40:0] p2_sum [0:3];
  logic signed [31:0] p2_in  [0:3];
  logic signed [31:0] p3_vel [0:3];
  logic               p3_ov, p3_resp;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      p2_sum[l] = 41'(p2_cm[l % 2]) + 41'(p2_prod[l] >>> 16);
    end
    p2_in[LANE_AX] = p2_c.avx;
    p2_in[LANE_AY] = p2_c.avy;
    p2_in[LANE_BX] = p2_c.bvx;
    p2_in[LANE_BY] = p2_c.bvy;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        p3_vel[l] <= p2_c.resp ? sat32(p2_sum[l]) : p2_in[l];
      end
      p3_ov   <= p2_c.ov;
      p3_resp <= p2_c.resp;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      overlap     <= p3_ov;
      responded   <= p3_resp;
      new_a_vel_x <= p3_vel[LANE_AX];
      new_a_vel_y <= p3_vel[LANE_AY];
      new_b_vel_x <= p3_vel[LANE_BX];
      new_b_vel_y <= p3_vel[LANE_BY];
    end
  end

  `BPCR_ASSERT_NOW(a_resp_needs_overlap, out_valid, !responded || overlap, "response without overlap")
  `BPCR_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, vld[0], "accepted word lost at entry")
  `BPCR_ASSERT_NEXT(a_tail_held, vld[NS-1] && in_stall, vld[NS-1] && out_valid, "stalled word dropped")

endmodule

>>> tb/sv/bpcr_checker.sv
// ----------------------------------------------------------------------------
// bpcr_checker
// Watches both channels and the restitution port of the collision response
// block, predicts each output word from the accepted input word and compares
// every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bpcr_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [16:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] a_pos_x,
  input  logic signed [31:0] a_pos_y,
  input  logic signed [31:0] b_pos_x,
  input  logic signed [31:0] b_pos_y,
  input  logic [30:0]        a_radius,
  input  logic [30:0]        b_radius,
  input  logic signed [31:0] a_vel_x,
  input  logic signed [31:0] a_vel_y,
  input  logic signed [31:0] b_vel_x,
  input  logic signed [31:0] b_vel_y,
  input  logic [15:0]        a_mass,
  input  logic [15:0]        b_mass,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               overlap,
  input  logic               responded,
  input  logic signed [31:0] new_a_vel_x,
  input  logic signed [31:0] new_a_vel_y,
  input  logic signed [31:0] new_b_vel_x,
  input  logic signed [31:0] new_b_vel_y,
  output int                 pending,
  output int                 fail_count
);

  import bpcr_pkg::*;

  typedef struct packed {
    logic               ov;
    logic               resp;
    logic signed [31:0] avx;
    logic signed [31:0] avy;
    logic signed [31:0] bvx;
    logic signed [31:0] bvy;
  } bounce_t;

  logic [16:0] rest_q;
  bounce_t     bounce_q[$];

  function automatic logic signed [31:0] clip32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  // impulse quotient, truncated toward zero, magnitude capped at 2^40
  function automatic logic signed [63:0] impulse(input logic signed [159:0] n,
                                                 input logic signed [159:0] d);
    logic signed [159:0] q;
    q = n / d;
    if (q > (160'sd1 <<< 40)) q = 160'sd1 <<< 40;
    if (q < -(160'sd1 <<< 40)) q = -(160'sd1 <<< 40);
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] bounce_scale(input logic signed [63:0] x,
                                                      input logic [16:0] r);
    logic signed [63:0] rr;
    logic signed [63:0] p;
    rr = {47'b0, r};
    p = x * rr;
    return p >>> 16;
  endfunction

  function automatic bounce_t predict_bounce(
      input logic signed [31:0] ax, ay, bx, by,
      input logic [30:0] ra, rb,
      input logic signed [31:0] avx, avy, bvx, bvy,
      input logic [15:0] ma, mb, input logic [16:0] r);
    logic signed [159:0] dx, dy, dsq, rs2, dot, den, tx, ty, ka, kb;
    logic [159:0]        rsum;
    logic signed [63:0]  m1, m2, mt, cmx, cmy, nax, nay, nbx, nby;
    bounce_t             res;
    dx = bx - ax;
    dy = by - ay;
    dsq = dx * dx + dy * dy;
    rsum = ra;
    rsum = rsum + rb;
    rs2 = rsum * rsum;
    dot = (bvx - avx) * dx + (bvy - avy) * dy;
    res.ov = dsq < rs2;
    res.resp = res.ov && (dot < 0);
    nax = avx; nay = avy; nbx = bvx; nby = bvy;
    if (res.resp) begin
      m1 = {48'b0, ma};
      m2 = {48'b0, mb};
      if (m1 == 0 && m2 == 0) begin
        m1 = 1;
        m2 = 1;
      end
      mt = m1 + m2;
      den = mt * dsq;
      tx = dot * dx;
      ty = dot * dy;
      ka = 2 * m2;
      kb = -2 * m1;
      nax = nax + impulse(tx * ka, den);
      nay = nay + impulse(ty * ka, den);
      nbx = nbx + impulse(tx * kb, den);
      nby = nby + impulse(ty * kb, den);
      cmx = (m1 * avx + m2 * bvx) / mt;
      cmy = (m1 * avy + m2 * bvy) / mt;
      nax = cmx + bounce_scale(nax - cmx, r);
      nay = cmy + bounce_scale(nay - cmy, r);
      nbx = cmx + bounce_scale(nbx - cmx, r);
      nby = cmy + bounce_scale(nby - cmy, r);
    end
    res.avx = clip32(nax);
    res.avy = clip32(nay);
    res.bvx = clip32(nbx);
    res.bvy = clip32(nby);
    return res;
  endfunction

  assign pending = bounce_q.size();

  always @(posedge clk) begin
    bounce_t want;
    if (rst) begin
      rest_q <= REST_RESET;
      fail_count <= 0;
    end else begin
      if (cfg_write) rest_q <= cfg_data;
      if (in_valid && !in_stall)
        bounce_q.push_back(predict_bounce(a_pos_x, a_pos_y, b_pos_x, b_pos_y,
                                          a_radius, b_radius, a_vel_x, a_vel_y,
                                          b_vel_x, b_vel_y, a_mass, b_mass, rest_q));
      if (out_valid && !out_stall) begin
        if (bounce_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output word at %0t", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = bounce_q.pop_front();
          if (want.ov !== overlap || want.resp !== responded ||
              want.avx !== new_a_vel_x || want.avy !== new_a_vel_y ||
              want.bvx !== new_b_vel_x || want.bvy !== new_b_vel_y) begin
            if (fail_count < 10)
              $display({"mismatch at %0t: exp ov=%0b rs=%0b %0d %0d %0d %0d,",
                        " got ov=%0b rs=%0b %0d %0d %0d %0d"},
                       $realtime, want.ov, want.resp,
                       want.avx, want.avy, want.bvx, want.bvy,
                       overlap, responded,
                       new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives disc pairs into the collision response block under random idling
// on both channels, across several restitution settings; the checker does
// the prediction and comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [16:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] a_pos_x = '0, a_pos_y = '0, b_pos_x = '0, b_pos_y = '0;
  logic [30:0] a_radius = '0, b_radius = '0;
  logic signed [31:0] a_vel_x = '0, a_vel_y = '0, b_vel_x = '0, b_vel_y = '0;
  logic [15:0] a_mass = 16'd1, b_mass = 16'd1;
  logic out_valid;
  logic out_stall = 1'b0;
  logic overlap, responded;
  logic signed [31:0] new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y;
  int pending, fail_count;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ball_pair_collision_response u_dut (.*);
  bpcr_checker u_chk (.*);

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver stall bursts
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_pair(input logic signed [31:0] ax, ay, bx, by,
                           input logic [30:0] ra, rb,
                           input logic signed [31:0] avx, avy, bvx, bvy,
                           input logic [15:0] ma, mb);
    int n;
    a_pos_x <= ax; a_pos_y <= ay; b_pos_x <= bx; b_pos_y <= by;
    a_radius <= ra; b_radius <= rb;
    a_vel_x <= avx; a_vel_y <= avy; b_vel_x <= bvx; b_vel_y <= bvy;
    a_mass <= ma; b_mass <= mb;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 10);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rnd_scaled(input int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (32 - bits);
  endfunction

  task automatic send_random();
    logic signed [31:0] ax, ay, ox, oy;
    logic [30:0] ra, rb;
    logic [15:0] ma, mb;
    int s, v;
    ax = $urandom;
    ay = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      ma = 16'($urandom_range(1, 65535));
      mb = 16'($urandom_range(1, 65535));
      send_pair(ax, ay, $urandom, $urandom, 31'($urandom), 31'($urandom),
                $urandom, $urandom, $urandom, $urandom, ma, mb);
    end else begin
      // close pair with radii on the scale of the gap
      s = $urandom_range(2, 30);
      v = $urandom_range(4, 32);
      ox = rnd_scaled(s + 1);
      oy = rnd_scaled(s + 1);
      ra = 31'($urandom_range(0, (1 << s) - 1));
      rb = 31'($urandom_range(0, (1 << s) - 1));
      ma = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 512));
      mb = 16'($urandom_range(1, 65535));
      send_pair(ax, ay, ax + ox, ay + oy, ra, rb, rnd_scaled(v), rnd_scaled(v),
                rnd_scaled(v), rnd_scaled(v), ma, mb);
    end
  endtask

  task automatic set_restitution(input logic [16:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam logic [30:0] RMAX = 31'h7fffffff;

  initial begin
    logic [16:0] rest_set[6];
    rest_set = '{17'd0, 17'd65536, 17'd1, 17'd32768, 17'd60293, 17'd0};
    rest_set[5] = 17'($urandom_range(0, 65536));
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset restitution
    send_pair(0, 0, 32'sh10000, 0, 31'h10000, 31'h10000, 32'sh10000, 0, -32'sh10000, 0,
              16'h100, 16'h100);                       // head-on, equal masses
    send_pair(0, 0, 32'sh10000, 0, 31'h10000, 31'h10000, -32'sh10000, 0, 32'sh10000, 0,
              16'h100, 16'h100);                       // separating
    send_pair(0, 0, 32'sh10000, 0, 31'h10000, 31'h10000, 32'sh10000, 0, -32'sh10000, 0,
              16'd0, 16'd0);                           // both massless
    send_pair(0, 0, 32'sh10000, 32'sh8000, 31'h10000, 31'h10000, 32'sh10000, 0, 0, 0,
              16'd0, 16'h100);                         // one massless
    send_pair(5, 5, 5, 5, RMAX, RMAX, SMAX, SMIN, SMIN, SMAX, 1, 65535); // same centre
    send_pair(SMIN, SMIN, SMAX, SMAX, RMAX, RMAX, SMAX, SMAX, SMIN, SMIN,
              16'd65535, 16'd1);                       // far apart, huge approach
    send_pair(SMAX, SMAX, SMIN, SMIN, 0, 0, 0, 0, 0, 0, 1, 1);  // zero radii
    send_pair(0, 0, 1, 1, RMAX, RMAX, SMAX, SMAX, SMIN, SMIN, 16'd65535, 16'd65535);
    send_pair(0, 0, 1, 0, 1, 0, SMAX, 0, SMIN, 0, 1, 16'd65535);   // touching only
    send_pair(0, 0, 32'sh30000, 32'sh40000, 31'h30000, 31'h30000, 32'sh20000, 32'sh20000,
              -32'sh10000, -32'sh30000, 16'd1, 16'd65535);
    send_pair(-100, 200, 100, -200, 300, 300, 7, -9, -7, 9, 16'd300, 16'd40000);
    send_pair(0, 0, 0, 2, 1, 0, 0, 0, 0, -1, 16'd1, 16'd1);        // just not overlapping
    send_pair(0, 0, 0, 2, 1, 1, 0, 0, 0, -1, 16'd1, 16'd1);        // touching only
    send_pair(0, 0, 0, 1, 1, 1, 0, 0, 0, -1, 16'd1, 16'd1);
    repeat (200) send_random();

    foreach (rest_set[i]) begin
      set_restitution(rest_set[i]);
      if (i == 1) begin
        send_pair(0, 0, 1, 0, 1, 0, SMAX, 0, SMIN, 0, 16'd65535, 1);
        send_pair(0, 0, 32'sh10000, 0, 31'h10000, 31'h10000, SMAX, SMIN, SMIN, SMAX,
                  16'd1, 16'd1);
      end
      if (i == 5) quiet = 1'b1;
      repeat (225) send_random();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
